### design/rsrn_pkg.sv
// Shared types and constants for the ring slot relay node.
// No dependencies; used by rsrn_core and ring_slot_relay_node.
package rsrn_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_OVERRUN = 2'd1,
        CMD_IDLE    = 2'd2,
        CMD_BUTTON  = 2'd3
    } t_cmd;

    localparam logic [7:0] DATA_CODE_RESET = 8'hA5;
    localparam logic [7:0] ENUM_CODE_RESET = 8'h5A;

    localparam logic [7:0] REG_DATA_CODE = 8'd0;
    localparam logic [7:0] REG_ENUM_CODE = 8'd1;

    // button_bits layout
    localparam int BTN_LEVEL  = 0;
    localparam int BTN_STICKY = 1;

    localparam int LED_VIEW_BYTES = 6;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] rx_byte;
        logic       button_level;
    } t_item;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        refresh_pulse;
        logic [47:0] led_bytes;
        logic        is_enumerated;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] index;
        logic [7:0] data;
    } t_cfg_wr;

endpackage

### design/rsrn_core.sv
// Per-byte relay logic and frame state of the ring slot relay node.
// Depends on rsrn_pkg.
module rsrn_core #(
    parameter int HEADER_BYTES  = 2,
    parameter int SLOT_BYTES    = 7,
    parameter int LED_BYTES     = 6,
    parameter int POSITION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsrn_pkg::t_cfg_wr  i_cfg,
    input  logic               i_fire,
    input  rsrn_pkg::t_item    i_item,
    output rsrn_pkg::t_result  o_result
);

    localparam int CMP_W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
    localparam int IDX_W = (LED_BYTES > 1) ? $clog2(LED_BYTES) : 1;

    logic [7:0]               r_data_code;
    logic [7:0]               r_enum_code;
    logic [POSITION_BITS-1:0] r_pos,        n_pos;
    logic                     r_in_sync,    n_in_sync;
    logic [7:0]               r_kind,       n_kind;
    logic                     r_enumerated, n_enumerated;
    logic [15:0]              r_led_off,    n_led_off;
    logic [15:0]              r_btn_off,    n_btn_off;
    logic [7:0]               r_led [LED_BYTES];
    logic [7:0]               n_led [LED_BYTES];
    logic [1:0]               r_btn,        n_btn;
    logic                     r_last_level, n_last_level;

    logic [CMP_W-1:0] pos_x, led_lo, led_hi, led_diff;
    logic             led_hit;
    logic             btn_hit;
    logic [7:0]       tx_byte;
    logic             tx_valid;
    logic             refresh;
    logic [47:0]      led_view;

    assign pos_x    = CMP_W'(r_pos);
    assign led_lo   = CMP_W'(r_led_off);
    assign led_hi   = led_lo + CMP_W'(LED_BYTES);
    assign led_diff = pos_x - led_lo;
    assign led_hit  = (pos_x >= led_lo) && (pos_x < led_hi);
    assign btn_hit  = (pos_x == CMP_W'(r_btn_off));

    always_comb begin
        n_pos        = r_pos;
        n_in_sync    = r_in_sync;
        n_kind       = r_kind;
        n_enumerated = r_enumerated;
        n_led_off    = r_led_off;
        n_btn_off    = r_btn_off;
        n_led        = r_led;
        n_btn        = r_btn;
        n_last_level = r_last_level;
        tx_valid     = 1'b0;
        tx_byte      = 8'd0;
        refresh      = 1'b0;

        case (i_item.command)
            rsrn_pkg::CMD_BYTE, rsrn_pkg::CMD_OVERRUN: begin
                tx_valid = 1'b1;
                tx_byte  = i_item.rx_byte;
                if (i_item.command == rsrn_pkg::CMD_OVERRUN) begin
                    n_in_sync = 1'b0;
                end else if (r_in_sync) begin
                    if (r_pos == '0) begin
                        n_kind = i_item.rx_byte;
                    end else if (r_kind == r_enum_code) begin
                        if (r_pos == POSITION_BITS'(1)) begin
                            n_led_off    = 16'(HEADER_BYTES)
                                         + 16'(i_item.rx_byte) * 16'(SLOT_BYTES);
                            n_btn_off    = n_led_off + 16'(LED_BYTES);
                            n_enumerated = 1'b1;
                            tx_byte      = i_item.rx_byte + 8'd1;
                        end
                    end else if (r_enumerated) begin
                        if (led_hit) begin
                            for (int e = 0; e < LED_BYTES; e++) begin
                                if (led_diff[IDX_W-1:0] == IDX_W'(e)) begin
                                    n_led[e] = i_item.rx_byte;
                                end
                            end
                        end else if (btn_hit) begin
                            // report button bits, sticky press is consumed
                            tx_byte            = {6'd0, r_btn};
                            n_btn[rsrn_pkg::BTN_STICKY] = 1'b0;
                        end
                    end
                end
                if (r_pos != '1) begin
                    n_pos = r_pos + POSITION_BITS'(1);
                end
            end
            rsrn_pkg::CMD_IDLE: begin
                refresh   = r_in_sync && (r_kind == r_data_code) && r_enumerated;
                n_in_sync = 1'b1;
                n_pos     = '0;
            end
            default: begin
                if (i_item.button_level && !r_last_level) begin
                    n_btn[rsrn_pkg::BTN_STICKY] = 1'b1;
                end
                n_btn[rsrn_pkg::BTN_LEVEL] = i_item.button_level;
                n_last_level = i_item.button_level;
            end
        endcase
    end

    // LED view: entry 0 in the top byte, missing entries read as zero
    for (genvar k = 0; k < rsrn_pkg::LED_VIEW_BYTES; k++) begin : g_view
        if (k < LED_BYTES) begin : g_on
            assign led_view[47-8*k -: 8] = n_led[k];
        end else begin : g_off
            assign led_view[47-8*k -: 8] = 8'd0;
        end
    end

    assign o_result.tx_valid      = tx_valid;
    assign o_result.tx_byte       = tx_byte;
    assign o_result.refresh_pulse = refresh;
    assign o_result.led_bytes     = led_view;
    assign o_result.is_enumerated = n_enumerated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_code  <= rsrn_pkg::DATA_CODE_RESET;
            r_enum_code  <= rsrn_pkg::ENUM_CODE_RESET;
            r_pos        <= '0;
            r_in_sync    <= 1'b1;
            r_kind       <= 8'd0;
            r_enumerated <= 1'b0;
            r_led_off    <= '1;
            r_btn_off    <= '1;
            for (int e = 0; e < LED_BYTES; e++) begin
                r_led[e] <= 8'd0;
            end
            r_btn        <= 2'd0;
            r_last_level <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == rsrn_pkg::REG_DATA_CODE) begin
                    r_data_code <= i_cfg.data;
                end else if (i_cfg.index == rsrn_pkg::REG_ENUM_CODE) begin
                    r_enum_code <= i_cfg.data;
                end
            end
            if (i_fire) begin
                r_pos        <= n_pos;
                r_in_sync    <= n_in_sync;
                r_kind       <= n_kind;
                r_enumerated <= n_enumerated;
                r_led_off    <= n_led_off;
                r_btn_off    <= n_btn_off;
                r_led        <= n_led;
                r_btn        <= n_btn;
                r_last_level <= n_last_level;
            end
        end
    end

    a_idle_resyncs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.command == rsrn_pkg::CMD_IDLE) |=> (r_pos == '0) && r_in_sync)
        else $error("idle gap did not clear position and restore sync");

    a_overrun_drops_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.command == rsrn_pkg::CMD_OVERRUN) |=> !r_in_sync)
        else $error("overrun byte left the node in sync");

    a_enum_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enumerated |=> r_enumerated)
        else $error("enumerated flag fell without reset");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_pos) && $stable(r_btn))
        else $error("frame state changed with no item processed");

endmodule

### design/ring_slot_relay_node.sv
// Top level of the ring slot relay node: input register, relay core, result register.
// Depends on rsrn_pkg and rsrn_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event: a received byte,
//   a byte with overrun, an idle gap or a button sample. Every event yields
//   exactly one result on the output channel (o_out_valid / i_out_ready):
//   the relayed byte when o_tx_valid is set, the refresh pulse, the six
//   snooped LED bytes and the enumerated flag.
//   Configuration writes (i_cfg_valid / o_cfg_ready) set the data and
//   enumeration frame codes; the port is always ready and should be used only
//   while no item is in flight. Unknown register indexes are ignored.
// Timing:
//   Result valid rises once the input register has captured the item and the
//   relay result has been written into the result register; a stalled result
//   register holds the item back in the input register until it is taken.
//   Throughput is one item per cycle while the receiver takes each result,
//   set by the combinational relay logic and its registered state update.
// Reset and stall:
//   Synchronous active-low reset returns frame state and codes to their reset
//   values and empties both registers.
//   When the receiver stalls, the result register holds its item and the input
//   register fills; o_in_ready then drops until the result is taken.
module ring_slot_relay_node #(
    parameter int HEADER_BYTES  = 2,
    parameter int SLOT_BYTES    = 7,
    parameter int LED_BYTES     = 6,
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_button_level,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_refresh_pulse,
    output logic [47:0] o_led_bytes,
    output logic        o_is_enumerated
);

    logic              r_in_valid;
    rsrn_pkg::t_item   r_item;
    logic              r_out_valid;
    rsrn_pkg::t_result r_result;

    rsrn_pkg::t_cfg_wr cfg_wr;
    rsrn_pkg::t_result core_result;
    logic              advance;
    logic              in_xfer;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    rsrn_core #(
        .HEADER_BYTES  (HEADER_BYTES),
        .SLOT_BYTES    (SLOT_BYTES),
        .LED_BYTES     (LED_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_fire   (advance),
        .i_item   (r_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.command      <= rsrn_pkg::t_cmd'(i_command);
            r_item.rx_byte      <= i_rx_byte;
            r_item.button_level <= i_button_level;
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_valid      = r_result.tx_valid;
    assign o_tx_byte       = r_result.tx_byte;
    assign o_refresh_pulse = r_result.refresh_pulse;
    assign o_led_bytes     = r_result.led_bytes;
    assign o_is_enumerated = r_result.is_enumerated;

endmodule
